>>> rtl/wavetable_oscillator_interp_top_macros.svh
// Assertion macros used by the wavetable oscillator controller.
`ifndef WAVETABLE_OSCILLATOR_INTERP_TOP_MACROS_SVH
`define WAVETABLE_OSCILLATOR_INTERP_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define WTOI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wtoi assertion failed");
// Next-cycle implication.
`define WTOI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wtoi assertion failed");
`else
`define WTOI_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define WTOI_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/wtoi_pkg.sv
// Shared widths, codes and types of the wavetable oscillator.
package wtoi_pkg;

    localparam int PHASE_W   = 24;
    localparam int AMP_W     = 16;
    localparam int SAMPLE_W  = 16;
    localparam int INDEX_W   = 12;
    localparam int ACTION_W  = 2;

    localparam int DEF_TABLE_DEPTH = 4096;

    localparam logic [PHASE_W-1:0] RESET_INCREMENT = 24'd167392;
    localparam logic [AMP_W-1:0]   RESET_AMPLITUDE = 16'd6554;

    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_PHASE = 2'd2;

    typedef struct packed {
        logic tick;       // start a tick: read both taps, advance phase
        logic wr;         // write one table word
        logic ld_phase;   // load start phase
        logic ld_interp;  // capture interpolated value
        logic ld_prod;    // capture amplitude product
        logic ld_out;     // round, saturate, load output word
    } t_cmd;

endpackage

>>> rtl/wtoi_ram.sv
// Generic RAM: one write port, two registered read ports.
module wtoi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

>>> rtl/wtoi_ctrl.sv
// Sequencer of the wavetable oscillator: handshakes and datapath commands.
`include "wavetable_oscillator_interp_top_macros.svh"
module wtoi_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [wtoi_pkg::ACTION_W-1:0] i_action,
    input  logic                          i_out_stall,
    output logic                          o_in_stall,
    output logic                          o_out_valid,
    output wtoi_pkg::t_cmd                o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL1 = 2'd1;
    localparam logic [1:0] ST_MUL2 = 2'd2;
    localparam logic [1:0] ST_RND  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_accept;
    logic       w_slot_free;

    assign w_accept    = i_in_valid && (r_state == ST_IDLE);
    assign w_slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_cmd           = '0;
        o_cmd.tick      = w_accept && (i_action == wtoi_pkg::ACT_TICK);
        o_cmd.wr        = w_accept && (i_action == wtoi_pkg::ACT_WRITE);
        o_cmd.ld_phase  = w_accept && (i_action == wtoi_pkg::ACT_PHASE);
        o_cmd.ld_interp = (r_state == ST_MUL1);
        o_cmd.ld_prod   = (r_state == ST_MUL2);
        o_cmd.ld_out    = (r_state == ST_RND) && w_slot_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.tick) begin
                    n_state = ST_MUL1;
                end
            end
            ST_MUL1: n_state = ST_MUL2;
            ST_MUL2: n_state = ST_RND;
            ST_RND: begin
                // hold until the output word slot frees up
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.ld_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    `WTOI_ASSERT_NXT(a_tick_starts, i_clk, i_rst_n, o_cmd.tick, r_state == ST_MUL1)
    `WTOI_ASSERT_NXT(a_other_idle, i_clk, i_rst_n, o_cmd.wr || o_cmd.ld_phase, r_state == ST_IDLE)
    `WTOI_ASSERT_NXT(a_rnd_hold, i_clk, i_rst_n, (r_state == ST_RND) && !w_slot_free, r_state == ST_RND)
    `WTOI_ASSERT_NXT(a_ld_out_valid, i_clk, i_rst_n, o_cmd.ld_out, r_out_valid)
    `WTOI_ASSERT_IMP(a_one_accept, i_clk, i_rst_n, 1'b1, $onehot0({o_cmd.tick, o_cmd.wr, o_cmd.ld_phase}))

endmodule

>>> rtl/wtoi_datapath.sv
// Datapath: phase accumulator, table RAM, interpolation, gain, rounding.
module wtoi_datapath #(
    parameter int TABLE_DEPTH = wtoi_pkg::DEF_TABLE_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  wtoi_pkg::t_cmd                       i_cmd,
    input  logic [wtoi_pkg::INDEX_W-1:0]         i_table_index,
    input  logic signed [wtoi_pkg::SAMPLE_W-1:0] i_table_value,
    input  logic [wtoi_pkg::PHASE_W-1:0]         i_start_phase,
    input  logic [wtoi_pkg::PHASE_W-1:0]         i_phase_increment,
    input  logic [wtoi_pkg::AMP_W-1:0]           i_amplitude,
    output logic signed [wtoi_pkg::SAMPLE_W-1:0] o_sample
);

    localparam int PHW = wtoi_pkg::PHASE_W;
    localparam int SW  = wtoi_pkg::SAMPLE_W;
    localparam int AMW = wtoi_pkg::AMP_W;
    // fraction bits: floor(log2(2^24 / depth))
    localparam int S   = $clog2(((2 ** PHW) / TABLE_DEPTH) + 1) - 1;
    localparam int PW  = PHW - S;
    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int EW  = wtoi_pkg::INDEX_W + AW + 1;
    localparam int IPW = S + SW;
    localparam int VW  = IPW + AMW + 1;
    localparam int RW  = VW - (S + 15);

    localparam logic [PW:0]   DEPTH_P = (PW + 1)'(TABLE_DEPTH);
    localparam logic [EW-1:0] DEPTH_E = EW'(TABLE_DEPTH);
    localparam logic [VW-1:0] HALF    = {{(VW - S - 15){1'b0}}, 1'b1, {(S + 14){1'b0}}};

    logic [PHW-1:0]       r_phase;
    logic [S-1:0]         r_frac;
    logic signed [IPW-1:0] r_interp;
    logic signed [VW-1:0] r_prod;
    logic signed [SW-1:0] r_sample;

    // table position, wrapped at the depth
    logic [PW:0]   w_raw;
    logic [PW:0]   w_pos;
    logic [PW:0]   w_nxt_inc;
    logic [PW:0]   w_nxt;
    logic [EW-1:0] w_widx;
    logic          w_we;

    assign w_raw     = {1'b0, r_phase[PHW-1:S]};
    assign w_pos     = (w_raw >= DEPTH_P) ? (w_raw - DEPTH_P) : w_raw;
    assign w_nxt_inc = w_pos + (PW + 1)'(1);
    assign w_nxt     = (w_nxt_inc == DEPTH_P) ? '0 : w_nxt_inc;

    // drop writes past the table end
    assign w_widx = EW'(i_table_index);
    assign w_we   = i_cmd.wr && (w_widx < DEPTH_E);

    logic [SW-1:0] w_rd_a;
    logic [SW-1:0] w_rd_b;

    wtoi_ram #(
        .WIDTH (SW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_widx[AW-1:0]),
        .i_wdata   (i_table_value),
        .i_re      (i_cmd.tick),
        .i_raddr_a (w_pos[AW-1:0]),
        .i_raddr_b (w_nxt[AW-1:0]),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    // x1*2^S + (x2 - x1)*f
    logic signed [SW:0]     w_diff;
    logic signed [IPW+1:0]  w_dprod;
    logic signed [IPW+1:0]  w_base;
    logic signed [IPW+1:0]  w_interp;

    assign w_diff   = $signed({w_rd_b[SW-1], w_rd_b}) - $signed({w_rd_a[SW-1], w_rd_a});
    assign w_dprod  = w_diff * $signed({1'b0, r_frac});
    assign w_base   = $signed({{2{w_rd_a[SW-1]}}, w_rd_a, {S{1'b0}}});
    assign w_interp = w_base + w_dprod;

    logic signed [VW-1:0] w_scaled;
    assign w_scaled = r_interp * $signed({1'b0, i_amplitude});

    // round half up, then saturate
    logic [VW-1:0]         w_biased;
    logic signed [VW-1:0]  w_shifted;
    logic [RW-1:0]         w_round;
    logic signed [SW-1:0]  w_sat;

    assign w_biased  = r_prod + HALF;
    assign w_shifted = $signed(w_biased) >>> (S + 15);
    assign w_round   = w_shifted[RW-1:0];

    always_comb begin
        if (&w_round[RW-1:SW-1] || ~|w_round[RW-1:SW-1]) begin
            w_sat = $signed(w_round[SW-1:0]);
        end else if (w_round[RW-1]) begin
            w_sat = $signed({1'b1, {(SW - 1){1'b0}}});
        end else begin
            w_sat = $signed({1'b0, {(SW - 1){1'b1}}});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_cmd.ld_phase) begin
            r_phase <= i_start_phase;
        end else if (i_cmd.tick) begin
            r_phase <= r_phase + i_phase_increment;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick) begin
            r_frac <= r_phase[S-1:0];
        end
        if (i_cmd.ld_interp) begin
            r_interp <= w_interp[IPW-1:0];
        end
        if (i_cmd.ld_prod) begin
            r_prod <= w_scaled;
        end
        if (i_cmd.ld_out) begin
            r_sample <= w_sat;
        end
    end

    assign o_sample = r_sample;

endmodule

>>> rtl/wavetable_oscillator_interp_top.sv
// Wavetable oscillator with linear interpolation: top level and register port.
// A tick word passes from acceptance to the output register through the table RAM
// read of both neighbor taps at acceptance, the interpolation multiply, the
// amplitude multiply, then rounding and saturation; the input stalls from
// acceptance until the sample is loaded, and longer while an earlier sample
// waits downstream, so a new tick is not taken before the last one is through.
// Table writes and phase loads give no output word and leave the input unstalled.
// The table is not cleared after reset: read only written entries.
// Registers: 0x0 phase increment (24 bits), 0x4 amplitude (unsigned Q1.15).
module wavetable_oscillator_interp_top #(
    parameter int TABLE_DEPTH = wtoi_pkg::DEF_TABLE_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [wtoi_pkg::ACTION_W-1:0]        i_action,
    input  logic [wtoi_pkg::INDEX_W-1:0]         i_table_index,
    input  logic signed [wtoi_pkg::SAMPLE_W-1:0] i_table_value,
    input  logic [wtoi_pkg::PHASE_W-1:0]         i_start_phase,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [wtoi_pkg::SAMPLE_W-1:0] o_sample,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [2:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    localparam logic REG_INC = 1'b0;
    localparam logic REG_AMP = 1'b1;

    logic [wtoi_pkg::PHASE_W-1:0] r_phase_increment;
    logic [wtoi_pkg::AMP_W-1:0]   r_amplitude;
    logic                         w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_increment <= wtoi_pkg::RESET_INCREMENT;
            r_amplitude       <= wtoi_pkg::RESET_AMPLITUDE;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_INC: r_phase_increment <= pwdata[wtoi_pkg::PHASE_W-1:0];
                REG_AMP: r_amplitude       <= pwdata[wtoi_pkg::AMP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_INC: prdata = 32'(r_phase_increment);
            REG_AMP: prdata = 32'(r_amplitude);
            default: prdata = '0;
        endcase
    end

    wtoi_pkg::t_cmd w_cmd;

    wtoi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_action),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    wtoi_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_table_index     (i_table_index),
        .i_table_value     (i_table_value),
        .i_start_phase     (i_start_phase),
        .i_phase_increment (r_phase_increment),
        .i_amplitude       (r_amplitude),
        .o_sample          (o_sample)
    );

endmodule

>>> tb/wavetable_oscillator_interp_top_test.sv
// Self-checking testbench of the wavetable oscillator with linear interpolation.
`timescale 1ns / 1ps

module wavetable_oscillator_interp_top_test;

    localparam int PHASE_W  = wtoi_pkg::PHASE_W;
    localparam int AMP_W    = wtoi_pkg::AMP_W;
    localparam int SAMPLE_W = wtoi_pkg::SAMPLE_W;
    localparam int INDEX_W  = wtoi_pkg::INDEX_W;
    localparam int ACTION_W = wtoi_pkg::ACTION_W;
    localparam logic [PHASE_W-1:0] RESET_INCREMENT = wtoi_pkg::RESET_INCREMENT;
    localparam logic [AMP_W-1:0] RESET_AMPLITUDE = wtoi_pkg::RESET_AMPLITUDE;
    localparam logic [ACTION_W-1:0] ACT_TICK = wtoi_pkg::ACT_TICK;
    localparam logic [ACTION_W-1:0] ACT_WRITE = wtoi_pkg::ACT_WRITE;
    localparam logic [ACTION_W-1:0] ACT_PHASE = wtoi_pkg::ACT_PHASE;

    localparam int TABLE_WORDS = wtoi_pkg::DEF_TABLE_DEPTH;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SEGMENT_WORDS = 175;
    localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;
    localparam logic [2:0] ADDR_INCREMENT = 3'h0;
    localparam logic [2:0] ADDR_AMPLITUDE = 3'h4;

    // Tracks oscillator state and the samples still owed by the block.
    class osc_scoreboard;
        bit [PHASE_W-1:0] phase;
        bit [PHASE_W-1:0] increment;
        bit [AMP_W-1:0] gain;
        logic signed [SAMPLE_W-1:0] words[TABLE_WORDS];
        bit written[TABLE_WORDS];
        logic signed [SAMPLE_W-1:0] expected_samples[$];
        int frac_bits;
        int errors;

        function new();
            int span;
            span = (1 << PHASE_W) / TABLE_WORDS;
            frac_bits = 0;
            while (span > 1) begin
                span = span >> 1;
                frac_bits++;
            end
            phase = '0;
            increment = RESET_INCREMENT;
            gain = RESET_AMPLITUDE;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] addr, logic [31:0] data);
            if (addr == ADDR_INCREMENT) begin
                increment = data[PHASE_W-1:0];
            end else if (addr == ADDR_AMPLITUDE) begin
                gain = data[AMP_W-1:0];
            end
        endfunction

        function int head_tap();
            return (phase >> frac_bits) % TABLE_WORDS;
        endfunction

        function logic signed [SAMPLE_W-1:0] interpolate_sample();
            int pos;
            int nxt;
            longint x1;
            longint x2;
            longint frac;
            longint v;
            longint r;
            pos = head_tap();
            nxt = (pos + 1) % TABLE_WORDS;
            x1 = words[pos];
            x2 = words[nxt];
            frac = longint'(phase & ((1 << frac_bits) - 1));
            v = (x1 * (longint'(1) << frac_bits) + (x2 - x1) * frac) * longint'(gain);
            // round half up, then clip to the sample range
            r = (v + (longint'(1) << (frac_bits + 14))) >>> (frac_bits + 15);
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            return r[SAMPLE_W-1:0];
        endfunction

        function void note_word(logic [ACTION_W-1:0] act, logic [INDEX_W-1:0] idx,
                                logic signed [SAMPLE_W-1:0] val, logic [PHASE_W-1:0] ph);
            if (act == ACT_WRITE) begin
                if (idx < TABLE_WORDS) begin
                    words[idx] = val;
                    written[idx] = 1'b1;
                end
            end else if (act == ACT_PHASE) begin
                phase = ph;
            end else if (act == ACT_TICK) begin
                expected_samples.push_back(interpolate_sample());
                phase = phase + increment;
            end
        endfunction

        function void check_sample(logic signed [SAMPLE_W-1:0] got);
            logic signed [SAMPLE_W-1:0] want;
            if (expected_samples.size() == 0) begin
                $error("sample: expected none, got %0d", got);
                errors++;
            end else begin
                want = expected_samples.pop_front();
                if (got !== want) begin
                    $error("sample: expected %0d, got %0d", want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [ACTION_W-1:0] i_action = ACT_NONE;
    logic [INDEX_W-1:0] i_table_index = '0;
    logic signed [SAMPLE_W-1:0] i_table_value = '0;
    logic [PHASE_W-1:0] i_start_phase = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] o_sample;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    osc_scoreboard sb;
    int idle_pct = 0;
    int stall_pct = 0;
    int words_sent = 0;
    int cycles = 0;

    wavetable_oscillator_interp_top #(
        .TABLE_DEPTH(TABLE_WORDS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_action(i_action),
        .i_table_index(i_table_index),
        .i_table_value(i_table_value),
        .i_start_phase(i_start_phase),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_sample(o_sample),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Stall only changes at the rising edge, so a word seen here is taken at the next one.
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_sample(o_sample);
        end
    end

    function automatic logic [INDEX_W-1:0] rand_index();
        return INDEX_W'($urandom);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_value();
        return SAMPLE_W'($urandom);
    endfunction

    function automatic logic [PHASE_W-1:0] rand_phase();
        return PHASE_W'($urandom);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return rand_value();
        endcase
    endfunction

    // Called right after a rising edge; returns right after the edge that takes the word.
    task automatic send_word(input logic [ACTION_W-1:0] act, input logic [INDEX_W-1:0] idx,
                             input logic signed [SAMPLE_W-1:0] val,
                             input logic [PHASE_W-1:0] ph);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_table_index <= idx;
        i_table_value <= val;
        i_start_phase <= ph;
        @(negedge i_clk);
        while (o_in_stall) @(negedge i_clk);
        sb.note_word(act, idx, val, ph);
        words_sent++;
        @(posedge i_clk);
    endtask

    // Write any unwritten tap first so a tick never reads an empty entry.
    task automatic tick_word();
        int head;
        int tail;
        head = sb.head_tap();
        tail = (head + 1) % TABLE_WORDS;
        if (!sb.written[head]) send_word(ACT_WRITE, INDEX_W'(head), rand_sample(), rand_phase());
        if (!sb.written[tail]) send_word(ACT_WRITE, INDEX_W'(tail), rand_sample(), rand_phase());
        send_word(ACT_TICK, rand_index(), rand_value(), rand_phase());
    endtask

    task automatic random_word();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55) begin
            tick_word();
        end else if (pick < 80) begin
            send_word(ACT_WRITE, rand_index(), rand_sample(), rand_phase());
        end else if (pick < 92) begin
            send_word(ACT_PHASE, rand_index(), rand_value(), rand_phase());
        end else begin
            send_word(ACT_NONE, rand_index(), rand_value(), rand_phase());
        end
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (!pready) @(negedge i_clk);
        sb.write_reg(addr, data);
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drop valid, let every owed sample drain, then give the pipeline time to empty.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_samples.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    initial begin
        int seg;
        int target;
        logic [PHASE_W-1:0] inc;
        logic [AMP_W-1:0] amp;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset register values, end taps, fraction extremes, index wrap
        send_word(ACT_WRITE, 12'd0, 16'sh7FFF, rand_phase());
        send_word(ACT_WRITE, 12'd1, 16'sh8000, rand_phase());
        send_word(ACT_PHASE, rand_index(), rand_value(), 24'h000000);
        send_word(ACT_TICK, rand_index(), rand_value(), rand_phase());
        send_word(ACT_PHASE, rand_index(), rand_value(), 24'h000FFF);
        send_word(ACT_TICK, rand_index(), rand_value(), rand_phase());
        send_word(ACT_WRITE, 12'hFFF, 16'shFFFF, rand_phase());
        send_word(ACT_PHASE, rand_index(), rand_value(), 24'hFFFFFF);
        send_word(ACT_TICK, rand_index(), rand_value(), rand_phase());
        send_word(ACT_NONE, 12'hFFF, 16'shFFFF, 24'hFFFFFF);
        send_word(ACT_WRITE, 12'hAAA, 16'sh5555, rand_phase());
        send_word(ACT_WRITE, 12'h555, 16'shAAAA, rand_phase());
        send_word(ACT_PHASE, rand_index(), rand_value(), 24'hAAA800);
        tick_word();
        tick_word();

        // gain above unity: clip both ways; full-scale increment steps back one
        settle();
        reg_write(ADDR_INCREMENT, 32'h00FF_FFFF);
        reg_write(ADDR_AMPLITUDE, 32'h0000_FFFF);
        send_word(ACT_WRITE, 12'd2048, 16'sh7FFF, rand_phase());
        send_word(ACT_WRITE, 12'd2049, 16'sh7FFF, rand_phase());
        send_word(ACT_PHASE, rand_index(), rand_value(), 24'h800800);
        send_word(ACT_TICK, rand_index(), rand_value(), rand_phase());
        send_word(ACT_TICK, rand_index(), rand_value(), rand_phase());
        send_word(ACT_WRITE, 12'd2048, 16'sh8000, rand_phase());
        send_word(ACT_WRITE, 12'd2049, 16'sh8000, rand_phase());
        send_word(ACT_PHASE, rand_index(), rand_value(), 24'h800000);
        send_word(ACT_TICK, rand_index(), rand_value(), rand_phase());

        for (seg = 0; seg < 8; seg++) begin
            settle();
            case (seg)
                0: begin inc = 24'hFFFFFF; amp = 16'd32768; end
                1: begin inc = 24'h000000; amp = 16'hFFFF; end
                2: begin inc = 24'h000001; amp = 16'd0; end
                4: begin inc = 24'd4096; amp = 16'd32768; end
                5: begin
                    inc = PHASE_W'($urandom_range(300000, 1));
                    amp = AMP_W'($urandom_range(32768));
                end
                6: begin inc = PHASE_W'($urandom); amp = AMP_W'($urandom); end
                7: begin inc = RESET_INCREMENT; amp = RESET_AMPLITUDE; end
                default: begin inc = PHASE_W'($urandom); amp = AMP_W'($urandom_range(32768)); end
            endcase
            reg_write(ADDR_INCREMENT, {8'h00, inc});
            reg_write(ADDR_AMPLITUDE, {16'h0000, amp});
            case (seg / 2)
                0: begin idle_pct = 0; stall_pct = 0; end
                1: begin idle_pct = 67; stall_pct = 0; end
                2: begin idle_pct = 0; stall_pct = 67; end
                default: begin idle_pct = 16; stall_pct = 16; end
            endcase
            target = words_sent + SEGMENT_WORDS;
            while (words_sent < target) random_word();
        end

        settle();
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/wtoi_pkg.sv
rtl/wtoi_ram.sv
rtl/wtoi_ctrl.sv
rtl/wtoi_datapath.sv
rtl/wavetable_oscillator_interp_top.sv
tb/wavetable_oscillator_interp_top_test.sv
